FILE: hw/rtl/egc_pkg.sv
// Package for the encounter geometry classifier: widths, codes, sine table.
// No dependencies.
`default_nettype none
package egc_pkg;
    localparam int POS_BITS_DEF = 24;
    localparam int VEL_BITS_DEF = 16;
    localparam int ADDR_BITS = 5;

    typedef enum logic [1:0] {
        CLS_HEAD_ON  = 2'd0,
        CLS_OVERTAKE = 2'd1,
        CLS_GENERIC  = 2'd2
    } cls_t;

    localparam logic [ADDR_BITS-1:0] REG_MIN_SPEED = 5'd0;
    localparam logic [ADDR_BITS-1:0] REG_MARGIN    = 5'd4;
    localparam logic [ADDR_BITS-1:0] REG_HEAD_ANG  = 5'd8;
    localparam logic [ADDR_BITS-1:0] REG_OVT_ANG   = 5'd12;
    localparam logic [ADDR_BITS-1:0] REG_CPA_LIM   = 5'd16;

    typedef struct packed {
        logic [11:0] min_speed;
        logic [11:0] margin;
        logic [7:0]  head_ang;
        logic [7:0]  ovt_ang;
        logic [15:0] cpa_lim;
    } cfg_t;

    // round(16384*sin(d deg)), d = 0..90
    function automatic logic [14:0] sin_q14(input logic [6:0] d);
        logic [14:0] r;
        case (d)
            7'd0: r = 15'd0;      7'd1: r = 15'd286;    7'd2: r = 15'd572;
            7'd3: r = 15'd857;    7'd4: r = 15'd1143;   7'd5: r = 15'd1428;
            7'd6: r = 15'd1713;   7'd7: r = 15'd1997;   7'd8: r = 15'd2280;
            7'd9: r = 15'd2563;   7'd10: r = 15'd2845;  7'd11: r = 15'd3126;
            7'd12: r = 15'd3406;  7'd13: r = 15'd3686;  7'd14: r = 15'd3964;
            7'd15: r = 15'd4240;  7'd16: r = 15'd4516;  7'd17: r = 15'd4790;
            7'd18: r = 15'd5063;  7'd19: r = 15'd5334;  7'd20: r = 15'd5604;
            7'd21: r = 15'd5872;  7'd22: r = 15'd6138;  7'd23: r = 15'd6402;
            7'd24: r = 15'd6664;  7'd25: r = 15'd6924;  7'd26: r = 15'd7182;
            7'd27: r = 15'd7438;  7'd28: r = 15'd7692;  7'd29: r = 15'd7943;
            7'd30: r = 15'd8192;  7'd31: r = 15'd8438;  7'd32: r = 15'd8682;
            7'd33: r = 15'd8923;  7'd34: r = 15'd9162;  7'd35: r = 15'd9397;
            7'd36: r = 15'd9630;  7'd37: r = 15'd9860;  7'd38: r = 15'd10087;
            7'd39: r = 15'd10311; 7'd40: r = 15'd10531; 7'd41: r = 15'd10749;
            7'd42: r = 15'd10963; 7'd43: r = 15'd11174; 7'd44: r = 15'd11381;
            7'd45: r = 15'd11585; 7'd46: r = 15'd11786; 7'd47: r = 15'd11982;
            7'd48: r = 15'd12176; 7'd49: r = 15'd12365; 7'd50: r = 15'd12551;
            7'd51: r = 15'd12733; 7'd52: r = 15'd12911; 7'd53: r = 15'd13085;
            7'd54: r = 15'd13255; 7'd55: r = 15'd13421; 7'd56: r = 15'd13583;
            7'd57: r = 15'd13741; 7'd58: r = 15'd13894; 7'd59: r = 15'd14044;
            7'd60: r = 15'd14189; 7'd61: r = 15'd14330; 7'd62: r = 15'd14466;
            7'd63: r = 15'd14598; 7'd64: r = 15'd14726; 7'd65: r = 15'd14849;
            7'd66: r = 15'd14968; 7'd67: r = 15'd15082; 7'd68: r = 15'd15191;
            7'd69: r = 15'd15296; 7'd70: r = 15'd15396; 7'd71: r = 15'd15491;
            7'd72: r = 15'd15582; 7'd73: r = 15'd15668; 7'd74: r = 15'd15749;
            7'd75: r = 15'd15826; 7'd76: r = 15'd15897; 7'd77: r = 15'd15964;
            7'd78: r = 15'd16026; 7'd79: r = 15'd16083; 7'd80: r = 15'd16135;
            7'd81: r = 15'd16182; 7'd82: r = 15'd16225; 7'd83: r = 15'd16262;
            7'd84: r = 15'd16294; 7'd85: r = 15'd16322; 7'd86: r = 15'd16344;
            7'd87: r = 15'd16362; 7'd88: r = 15'd16374; 7'd89: r = 15'd16382;
            7'd90: r = 15'd16384;
            default: r = 15'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/encounter_geometry_classifier.sv
// Top level of the encounter geometry classifier: APB registers, products,
// class decision and the pipelined CPA divider. Depends on egc_pkg, egc_cpa_div.
// Pipeline: 22 register stages, the 17 one-bit divider stages plus 4 front
// stages and the output register.
// Throughput: one beat per cycle; a waiting output beat holds every stage.
// Reset clears valid bits and returns registers to their defaults.
`default_nettype none
module encounter_geometry_classifier #(
    parameter int POS_BITS = egc_pkg::POS_BITS_DEF,
    parameter int VEL_BITS = egc_pkg::VEL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [egc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // rel_north_m, rel_east_m, own_vel_north, own_vel_east,
    // intruder_vel_north, intruder_vel_east (lowest first)
    input  wire logic [((2*POS_BITS+4*VEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // enc_class[1:0], closing[2], cpa_time[18:3], cpa_saturated[19]
    output logic [23:0]                        m_tdata
);
    localparam int P = POS_BITS;
    localparam int V = VEL_BITS;
    localparam int DW = P + V + 3;        // dot product
    localparam int SW = 2 * V + 1;        // squared speed
    localparam int RW = 2 * P + 1;        // rho^2
    localparam int NW = RW + 12;
    localparam int CW = 2 * V + 2;        // cross/dot of velocities
    localparam int KW = CW + 17;          // C*y - S*x

    // configuration registers
    egc_pkg::cfg_t cfg_reg;
    logic wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_speed <= 12'd32;
            cfg_reg.margin    <= 12'd128;
            cfg_reg.head_ang  <= 8'd110;
            cfg_reg.ovt_ang   <= 8'd70;
            cfg_reg.cpa_lim   <= 16'd2048;
        end
        else if (wr)
        begin
            case (paddr)
                egc_pkg::REG_MIN_SPEED: cfg_reg.min_speed <= pwdata[11:0];
                egc_pkg::REG_MARGIN:    cfg_reg.margin    <= pwdata[11:0];
                egc_pkg::REG_HEAD_ANG:  cfg_reg.head_ang  <= pwdata[7:0];
                egc_pkg::REG_OVT_ANG:   cfg_reg.ovt_ang   <= pwdata[7:0];
                egc_pkg::REG_CPA_LIM:   cfg_reg.cpa_lim   <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb
    begin
        case (paddr)
            egc_pkg::REG_MIN_SPEED: prdata = {20'd0, cfg_reg.min_speed};
            egc_pkg::REG_MARGIN:    prdata = {20'd0, cfg_reg.margin};
            egc_pkg::REG_HEAD_ANG:  prdata = {24'd0, cfg_reg.head_ang};
            egc_pkg::REG_OVT_ANG:   prdata = {24'd0, cfg_reg.ovt_ang};
            egc_pkg::REG_CPA_LIM:   prdata = {16'd0, cfg_reg.cpa_lim};
            default:                prdata = 32'd0;
        endcase
    end

    // pipeline advance: hold everything while the output beat waits
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 1: unpack, products
    logic signed [P-1:0] rn, re;
    logic signed [V-1:0] ovn, ove, ivn, ive, wn;
    assign rn  = s_tdata[P-1:0];
    assign re  = s_tdata[2*P-1:P];
    assign ovn = s_tdata[2*P+V-1:2*P];
    assign ove = s_tdata[2*P+2*V-1:2*P+V];
    assign ivn = s_tdata[2*P+3*V-1:2*P+2*V];
    assign ive = s_tdata[2*P+4*V-1:2*P+3*V];
    assign wn  = (ivn == '0 && ive == '0) ? V'(1) : ivn;

    logic v1_reg;
    logic signed [P+V:0]   f1n_reg, f1e_reg, d1n_reg, d1e_reg;
    logic [2*V-1:0]        a1n_reg, a1e_reg, b1n_reg, b1e_reg;
    logic signed [2*V-1:0] xn_reg, xe_reg, cn_reg, ce_reg;
    logic [2*P-1:0]        r1n_reg, r1e_reg;
    logic signed [V:0]     dvn, dve;
    logic [P-1:0]          mrn, mre;
    assign dvn = {ivn[V-1], ivn} - {ovn[V-1], ovn};
    assign dve = {ive[V-1], ive} - {ove[V-1], ove};
    assign mrn = rn[P-1] ? P'(-rn) : P'(rn);
    assign mre = re[P-1] ? P'(-re) : P'(re);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1n_reg <= (P+V+1)'(rn * ovn);
            f1e_reg <= (P+V+1)'(re * ove);
            d1n_reg <= (P+V+1)'(rn * dvn);
            d1e_reg <= (P+V+1)'(re * dve);
            a1n_reg <= (2*V)'(ovn * ovn);
            a1e_reg <= (2*V)'(ove * ove);
            b1n_reg <= (2*V)'(ivn * ivn);
            b1e_reg <= (2*V)'(ive * ive);
            xn_reg  <= ovn * wn;
            xe_reg  <= ove * ive;
            cn_reg  <= ovn * ive;
            ce_reg  <= ove * wn;
            r1n_reg <= mrn * mrn;
            r1e_reg <= mre * mre;
        end
    end

    // stage 2: sums, trig lookup, margin square
    logic v2_reg, front2_reg, clos2_reg;
    logic [SW-1:0] a2_reg, b2_reg;
    logic signed [CW-1:0] x2_reg, y2_reg;
    logic [RW-1:0] r2_reg;
    logic [DW-1:0] den2_reg;
    logic signed [15:0] hs2_reg, hc2_reg, os2_reg, oc2_reg;
    logic [7:0] hd2_reg, od2_reg;
    logic [23:0] m2_reg;
    logic signed [DW-1:0] dot1;
    logic signed [CW-1:0] cr1;
    logic [7:0] hd1, od1;
    assign dot1 = DW'(d1n_reg) + DW'(d1e_reg);
    assign cr1  = CW'(cn_reg) - CW'(ce_reg);
    assign hd1  = cfg_reg.head_ang > 8'd180 ? 8'd180 : cfg_reg.head_ang;
    assign od1  = cfg_reg.ovt_ang > 8'd180 ? 8'd180 : cfg_reg.ovt_ang;

    function automatic logic [31:0] trig(input logic [7:0] t);
        logic [14:0] s, c;
        logic signed [15:0] cs;
        if (t <= 8'd90)
        begin
            s  = egc_pkg::sin_q14(7'(t));
            c  = egc_pkg::sin_q14(7'(8'd90 - t));
            cs = $signed({1'b0, c});
        end
        else
        begin
            s  = egc_pkg::sin_q14(7'(8'd180 - t));
            c  = egc_pkg::sin_q14(7'(t - 8'd90));
            cs = -$signed({1'b0, c});
        end
        return {1'b0, s, cs};
    endfunction

    logic [31:0] htr, otr;
    assign htr = trig(hd1);
    assign otr = trig(od1);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front2_reg <= ($signed(DW'(f1n_reg)) + $signed(DW'(f1e_reg))) > 0;
            clos2_reg  <= dot1 < 0;
            den2_reg   <= DW'(-dot1);
            a2_reg     <= SW'(a1n_reg) + SW'(a1e_reg);
            b2_reg     <= SW'(b1n_reg) + SW'(b1e_reg);
            x2_reg     <= CW'(xn_reg) + CW'(xe_reg);
            y2_reg     <= cr1 < 0 ? -cr1 : cr1;
            r2_reg     <= RW'(r1n_reg) + RW'(r1e_reg);
            hs2_reg    <= htr[31:16];
            hc2_reg    <= htr[15:0];
            os2_reg    <= otr[31:16];
            oc2_reg    <= otr[15:0];
            hd2_reg    <= hd1;
            od2_reg    <= od1;
            m2_reg     <= cfg_reg.margin * cfg_reg.margin;
        end
    end

    // stage 3: angle products, speed prep
    localparam int EW = SW + 2;
    logic v3_reg, front3_reg, clos3_reg, gen3_reg, hgt3_reg, olt3_reg, zero3_reg;
    logic signed [KW-1:0] hk3_reg, ok3_reg;
    logic signed [EW-1:0] d3_reg;
    logic [SW-1:0] a3_reg;
    logic [23:0] m3_reg;
    logic [RW-1:0] r3_reg;
    logic [DW-1:0] den3_reg;
    logic [7:0] hd3_reg, od3_reg;
    logic [15:0] lim3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gen3_reg   <= a2_reg < SW'(cfg_reg.min_speed * cfg_reg.min_speed);
            front3_reg <= front2_reg;
            clos3_reg  <= clos2_reg;
            hgt3_reg   <= y2_reg > 0 || x2_reg < 0;
            olt3_reg   <= y2_reg > 0 || x2_reg >= 0;
            zero3_reg  <= x2_reg == 0 && y2_reg == 0;
            hk3_reg    <= KW'(hc2_reg * y2_reg) - KW'(hs2_reg * x2_reg);
            ok3_reg    <= KW'(oc2_reg * y2_reg) - KW'(os2_reg * x2_reg);
            d3_reg     <= $signed(EW'(a2_reg)) + $signed(EW'(m2_reg))
                          - $signed(EW'(b2_reg));
            a3_reg     <= a2_reg;
            m3_reg     <= m2_reg;
            r3_reg     <= r2_reg;
            den3_reg   <= den2_reg;
            hd3_reg    <= hd2_reg;
            od3_reg    <= od2_reg;
            lim3_reg   <= cfg_reg.cpa_lim;
        end
    end

    // stage 4: speed squares for comparing d^2 with 4*m2*a, angle verdicts
    logic v4_reg, clos4_reg, gen4_reg, hon4_reg, olt4_reg, spd_ok4_reg;
    logic [2*EW-1:0] dd4_reg, ra4_reg;
    logic [RW-1:0] r4_reg;
    logic [DW-1:0] den4_reg;
    logic [15:0] lim4_reg;
    logic hon3, olt3;
    always_comb
    begin
        if (hd3_reg == 8'd0)
            hon3 = hgt3_reg;
        else if (hd3_reg >= 8'd180)
            hon3 = 1'b0;
        else
            hon3 = hk3_reg > 0;
        if (od3_reg == 8'd0)
            olt3 = 1'b0;
        else if (od3_reg >= 8'd180)
            olt3 = olt3_reg;
        else if (zero3_reg)
            olt3 = 1'b1;
        else
            olt3 = ok3_reg < 0;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            clos4_reg   <= clos3_reg;
            gen4_reg    <= gen3_reg || !front3_reg;
            hon4_reg    <= hon3;
            olt4_reg    <= olt3;
            spd_ok4_reg <= a3_reg > SW'(m3_reg) && d3_reg > 0;
            dd4_reg     <= (2*EW)'($unsigned(d3_reg) * $unsigned(d3_reg));
            ra4_reg     <= (2*EW)'({m3_reg, 2'b00} * a3_reg);
            r4_reg      <= r3_reg;
            den4_reg    <= den3_reg;
            lim4_reg    <= lim3_reg;
        end
    end

    // stage 5: class decision, divider feed
    egc_pkg::cls_t cls4;
    always_comb
    begin
        if (gen4_reg)
            cls4 = egc_pkg::CLS_GENERIC;
        else if (hon4_reg)
            cls4 = egc_pkg::CLS_HEAD_ON;
        else if (olt4_reg && spd_ok4_reg && dd4_reg > ra4_reg)
            cls4 = egc_pkg::CLS_OVERTAKE;
        else
            cls4 = egc_pkg::CLS_GENERIC;
    end

    logic dv;
    logic [15:0] dq, dlim;
    logic dsat;
    logic [2:0] dtag;
    egc_cpa_div #(.NUM_BITS(NW), .DEN_BITS(DW), .TAG_BITS(3)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (v4_reg),
        .in_num   ({r4_reg, 12'd0}),
        .in_den   (clos4_reg ? den4_reg : DW'(1)),
        .in_lim   (lim4_reg),
        .in_tag   ({clos4_reg, cls4}),
        .out_valid(dv),
        .out_quot (dq),
        .out_sat  (dsat),
        .out_lim  (dlim),
        .out_tag  (dtag)
    );

    // output register
    logic ov_reg;
    logic [19:0] od_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= dv;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dtag[2])
                od_reg <= {dsat, dq, dtag};
            else
                od_reg <= {1'b1, dlim, dtag};
        end
    end
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, od_reg};

    // checks
    a_cls_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad class code");
    a_notclose_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[2]) |-> m_tdata[19])
        else $error("not closing but not saturated");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow the output stage");
endmodule
`default_nettype wire

FILE: hw/rtl/egc_cpa_div.sv
// Pipelined restoring divider for the CPA time: one quotient bit per stage.
// No package dependencies; widths come only through parameters.
`default_nettype none
module egc_cpa_div #(
    parameter int NUM_BITS = 61,
    parameter int DEN_BITS = 42,
    parameter int TAG_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire logic [NUM_BITS-1:0] in_num,
    input  wire logic [DEN_BITS-1:0] in_den,
    input  wire logic [15:0]         in_lim,
    input  wire logic [TAG_BITS-1:0] in_tag,
    output logic                     out_valid,
    output logic [15:0]              out_quot,
    output logic                     out_sat,
    output logic [15:0]              out_lim,
    output logic [TAG_BITS-1:0]      out_tag
);
    localparam int NST = 17;

    // a 17-bit quotient covers every value up to lim+1 and beyond
    logic                valid_reg [1:NST];
    logic [NUM_BITS-1:0] rem_reg   [1:NST];
    logic [DEN_BITS-1:0] den_reg   [1:NST];
    logic [16:0]         q_reg     [1:NST];
    logic [15:0]         lim_reg   [1:NST];
    logic [TAG_BITS-1:0] tag_reg   [1:NST];

    // one quotient bit per stage, msb first (bit 16 down to 0)
    for (genvar g = 0; g < NST; g++)
    begin : g_st
        localparam int SH = NST - 1 - g;
        logic                 cur_valid;
        logic [NUM_BITS-1:0]  cur_rem;
        logic [DEN_BITS-1:0]  cur_den;
        logic [16:0]          cur_q;
        logic [15:0]          cur_lim;
        logic [TAG_BITS-1:0]  cur_tag;
        logic [NUM_BITS+17:0] dsh;
        logic                 take;
        // feed the first stage straight from the inputs
        if (g == 0)
        begin : g_src
            assign cur_valid = in_valid;
            assign cur_rem   = in_num;
            assign cur_den   = in_den;
            assign cur_q     = '0;
            assign cur_lim   = in_lim;
            assign cur_tag   = in_tag;
        end
        else
        begin : g_src
            assign cur_valid = valid_reg[g];
            assign cur_rem   = rem_reg[g];
            assign cur_den   = den_reg[g];
            assign cur_q     = q_reg[g];
            assign cur_lim   = lim_reg[g];
            assign cur_tag   = tag_reg[g];
        end
        assign dsh  = {{(NUM_BITS+18-DEN_BITS){1'b0}}, cur_den} << SH;
        assign take = {18'd0, cur_rem} >= dsh;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g+1] <= 1'b0;
            else if (adv)
                valid_reg[g+1] <= cur_valid;
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g+1] <= take ? cur_rem - dsh[NUM_BITS-1:0] : cur_rem;
                den_reg[g+1] <= cur_den;
                q_reg[g+1]   <= cur_q | (take ? (17'd1 << SH) : 17'd0);
                lim_reg[g+1] <= cur_lim;
                tag_reg[g+1] <= cur_tag;
            end
        end
    end

    // q > lim saturates
    assign out_valid = valid_reg[NST];
    assign out_sat   = q_reg[NST] > {1'b0, lim_reg[NST]};
    assign out_quot  = out_sat ? lim_reg[NST] : q_reg[NST][15:0];
    assign out_lim   = lim_reg[NST];
    assign out_tag   = tag_reg[NST];
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Testbench for encounter_geometry_classifier: directed and random encounters,
// checked beat by beat against a built-in predictor. Depends on egc_pkg and the RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = 24;
    localparam int VB = 16;
    localparam int DW = ((2*PB+4*VB+7)/8)*8;
    localparam int WATCHDOG = 20000;

    typedef struct {
        egc_pkg::cls_t cls;
        bit            closing;
        bit [15:0]     cpa;
        bit            sat;
    } verdict_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [egc_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 0;
    logic s_tready;
    // rel_north_m, rel_east_m, own_vel_north, own_vel_east,
    // intruder_vel_north, intruder_vel_east (lowest first)
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    // enc_class, closing, cpa_time, cpa_saturated (lowest first)
    logic [23:0] m_tdata;

    encounter_geometry_classifier u_top (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Shadow registers
    int unsigned min_speed = 32, margin = 128, head_ang = 110, ovt_ang = 70;
    int unsigned cpa_lim = 2048;

    verdict_t expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 0;
    bit rx_random = 1;

    // Sine table built from the Taylor series in Q30, rounded to Q14
    longint sine_rom[91];

    function automatic longint taylor_sin(int d);
        longint unsigned x, sum, term;
        x = longint'(d) * 64'd3373259426 / 180;
        sum = x;
        term = x;
        for (int k = 1; k <= 8; k++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / ((2*k) * (2*k + 1));
            if (k % 2 == 1) sum = (sum >= term) ? sum - term : 0;
            else sum = sum + term;
        end
        return longint'((sum + 32768) >> 16);
    endfunction

    function automatic bit track_diff_gt(longint x, longint y, int t);
        longint s, c;
        if (t == 0) return (y > 0) || (x < 0);
        if (t >= 180) return 0;
        s = sine_rom[t <= 90 ? t : 180 - t];
        c = t <= 90 ? sine_rom[90 - t] : -sine_rom[t - 90];
        return c * y - s * x > 0;
    endfunction

    function automatic bit track_diff_lt(longint x, longint y, int t);
        longint s, c;
        if (t == 0) return 0;
        if (t >= 180) return (y > 0) || (x >= 0);
        if (x == 0 && y == 0) return 1;
        s = sine_rom[t <= 90 ? t : 180 - t];
        c = t <= 90 ? sine_rom[90 - t] : -sine_rom[t - 90];
        return c * y - s * x < 0;
    endfunction

    // sqrt(a) > sqrt(b) + m, squared twice
    function automatic bit outruns(longint a, longint b, longint m);
        longint m2, d;
        logic signed [127:0] lhs, rhs;
        m2 = m * m;
        if (a <= m2) return 0;
        d = a + m2 - b;
        if (d <= 0) return 0;
        lhs = 128'(d) * 128'(d);
        rhs = 128'(4 * m2) * 128'(a);
        return lhs > rhs;
    endfunction

    function automatic verdict_t classify_encounter(logic [DW-1:0] w);
        verdict_t r;
        longint rn, re, ovn, ove, ivn, ive, a, b, wn, we, x, cr, y, dot;
        logic [127:0] num, den, lim;
        int hd, od;
        bit front;
        rn  = longint'($signed(w[23:0]));
        re  = longint'($signed(w[47:24]));
        ovn = longint'($signed(w[63:48]));
        ove = longint'($signed(w[79:64]));
        ivn = longint'($signed(w[95:80]));
        ive = longint'($signed(w[111:96]));
        a = ovn*ovn + ove*ove;
        b = ivn*ivn + ive*ive;
        r.cls = egc_pkg::CLS_GENERIC;
        if (a >= longint'(min_speed) * min_speed)
        begin
            front = rn*ovn + re*ove > 0;
            hd = head_ang > 180 ? 180 : head_ang;
            od = ovt_ang > 180 ? 180 : ovt_ang;
            wn = ivn;
            we = ive;
            // still intruder counts as a north track
            if (wn == 0 && we == 0) wn = 1;
            x = ovn*wn + ove*we;
            cr = ovn*we - ove*wn;
            y = cr < 0 ? -cr : cr;
            if (front && track_diff_gt(x, y, hd)) r.cls = egc_pkg::CLS_HEAD_ON;
            else if (front && track_diff_lt(x, y, od) && outruns(a, b, margin))
                r.cls = egc_pkg::CLS_OVERTAKE;
        end
        dot = rn*(ivn - ovn) + re*(ive - ove);
        r.closing = dot < 0;
        if (!r.closing)
        begin
            r.cpa = 16'(cpa_lim);
            r.sat = 1;
        end
        else
        begin
            num = 128'(rn*rn + re*re) << 12;
            den = 128'(-dot);
            lim = 128'(cpa_lim);
            if ((lim + 1) * den <= num)
            begin
                r.cpa = 16'(cpa_lim);
                r.sat = 1;
            end
            else
            begin
                r.cpa = 16'(num / den);
                r.sat = 0;
            end
        end
        return r;
    endfunction

    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
    endtask

    // Offer one encounter and wait until it is taken
    task automatic send_encounter(longint rn, longint re, longint ovn, longint ove,
                                  longint ivn, longint ive);
        logic [DW-1:0] w;
        w = '0;
        w[23:0] = rn[23:0];
        w[47:24] = re[23:0];
        w[63:48] = ovn[15:0];
        w[79:64] = ove[15:0];
        w[95:80] = ivn[15:0];
        w[111:96] = ive[15:0];
        s_tvalid <= 1;
        s_tdata <= w;
        expected_q.push_back(classify_encounter(w));
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if ($urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 0;
            pause_random();
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [egc_pkg::ADDR_BITS-1:0] addr, int unsigned value);
        psel <= 1;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (addr)
            egc_pkg::REG_MIN_SPEED: min_speed = value & 12'hFFF;
            egc_pkg::REG_MARGIN:    margin = value & 12'hFFF;
            egc_pkg::REG_HEAD_ANG:  head_ang = value & 8'hFF;
            egc_pkg::REG_OVT_ANG:   ovt_ang = value & 8'hFF;
            egc_pkg::REG_CPA_LIM:   cpa_lim = value & 16'hFFFF;
            default: ;
        endcase
        // bus idle between transfers
        @(posedge clk);
    endtask

    task automatic set_all(int unsigned ms, int unsigned mg, int unsigned ha,
                           int unsigned oa, int unsigned cl);
        write_reg(egc_pkg::REG_MIN_SPEED, ms);
        write_reg(egc_pkg::REG_MARGIN, mg);
        write_reg(egc_pkg::REG_HEAD_ANG, ha);
        write_reg(egc_pkg::REG_OVT_ANG, oa);
        write_reg(egc_pkg::REG_CPA_LIM, cl);
    endtask

    function automatic longint rnd_pos();
        case ($urandom_range(0, 3))
            0: return longint'($signed(24'($urandom)));
            1: return $signed(longint'($urandom_range(0, 4000))) - 2000;
            default: return $signed(longint'($urandom_range(0, 200000))) - 100000;
        endcase
    endfunction

    function automatic longint rnd_vel();
        case ($urandom_range(0, 4))
            0: return longint'($signed(16'($urandom)));
            1: return $signed(longint'($urandom_range(0, 40))) - 20;
            default: return $signed(longint'($urandom_range(0, 8000))) - 4000;
        endcase
    endfunction

    // Intruder ahead on own track half the time; its velocity opposite own, slower along own, or random
    task automatic send_geometric();
        longint rn, re, ovn, ove, ivn, ive, k;
        rn = rnd_pos();
        re = rnd_pos();
        ovn = rnd_vel();
        ove = rnd_vel();
        case ($urandom_range(0, 3))
            0:
            begin
                ivn = -ovn + $signed(longint'($urandom_range(0, 400))) - 200;
                ive = -ove + $signed(longint'($urandom_range(0, 400))) - 200;
            end
            1:
            begin
                k = $urandom_range(1, 4);
                ivn = ovn / (k + 1);
                ive = ove / (k + 1);
            end
            default:
            begin
                ivn = rnd_vel();
                ive = rnd_vel();
            end
        endcase
        if ($urandom_range(0, 1)) begin rn = ovn * 37; re = ove * 37; end
        if (rn > 8388607 || rn < -8388608) rn = rn / 8;
        if (re > 8388607 || re < -8388608) re = re / 8;
        if (ivn > 32767) ivn = 32767;
        if (ivn < -32768) ivn = -32768;
        if (ive > 32767) ive = 32767;
        if (ive < -32768) ive = -32768;
        send_encounter(rn, re, ovn, ove, ivn, ive);
    endtask

    task automatic test_directed();
        send_encounter(8388607, -8388608, 32767, -32768, -32768, 32767);
        send_encounter(-8388608, 8388607, -32768, 32767, 32767, -32768);
        send_encounter(-1, -1, -1, -1, -1, -1);
        send_encounter(0, 0, 0, 0, 0, 0);
        send_encounter(1000, 0, 1600, 0, 0, 0);        // still intruder
        send_encounter(1000, 0, 1600, 0, -1600, 0);    // head-on
        send_encounter(1000, 0, 3200, 0, 800, 0);      // overtake
        send_encounter(1000, 0, 3200, 0, 3200, 0);     // same speed
        send_encounter(-1000, 0, 1600, 0, -1600, 0);   // behind
        send_encounter(1000, 50, 10, 0, -10, 0);       // slow ownship
        send_encounter(100, 0, 0, 0, 1600, 0);         // opening
        send_encounter(1, 0, 0, 0, -16, 0);            // tiny time
        send_encounter(5000000, 5000000, 1, 1, 0, 0);  // far beyond the limit
        drain();
    endtask

    task automatic test_config_extremes();
        set_all(0, 0, 0, 0, 0);
        send_encounter(1000, 0, 0, 0, 0, 0);
        send_encounter(1000, 0, 1600, 0, 1600, 0);
        send_encounter(1000, 0, 1600, 0, -1600, 0);
        drain();
        set_all(4095, 4095, 255, 255, 65535);
        send_encounter(1000, 0, 32767, 0, -100, 0);
        send_encounter(8388607, 8388607, 0, 0, 1, 1);
        send_encounter(1000, 0, 32767, 0, 1000, 0);
        drain();
        set_all(0, 0, 180, 180, 1);
        repeat (8) send_geometric();
        drain();
        write_reg(5'd20, 32'hFFFF_FFFF);   // unmapped
        set_all(32'hFFFF_F020, 128, 90, 89, 2048);
        repeat (8) send_geometric();
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_encounter(rnd_pos(), rnd_pos(), rnd_vel(), rnd_vel(),
                               rnd_vel(), rnd_vel());
            else
                send_geometric();
        end
        drain();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++)
        begin
            set_all($urandom_range(0, 200), $urandom_range(0, 4095),
                    $urandom_range(0, 255), $urandom_range(0, 200),
                    $urandom_range(0, 65535));
            test_random(200);
        end
        set_all(32, 128, 110, 70, 2048);
        test_random(80);
    endtask

    // Long receiver hold-off while items keep coming
    task automatic test_backpressure();
        rx_random = 0;
        hold_off = 1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            repeat (60) send_geometric();
        join
        rx_random = 1;
        drain();
    endtask

    // Receiver ready
    always @(posedge clk)
    begin
        if (hold_off) m_tready <= 0;
        else if (!rx_random) m_tready <= 1;
        else if ($urandom_range(0, 39) == 0) m_tready <= 0;
        else if ($urandom_range(0, 2) != 0) m_tready <= 1;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", m_tdata);
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[1:0] !== e.cls || m_tdata[2] !== e.closing ||
                    m_tdata[18:3] !== e.cpa || m_tdata[19] !== e.sat)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp cls %0d cl %0d t %0d sat %0d, got %h",
                                 e.cls, e.closing, e.cpa, e.sat, m_tdata);
                end
            end
        end
    end

    // Watchdog on cycles with no beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        for (int d = 0; d <= 90; d++) sine_rom[d] = taylor_sin(d);
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_settings();
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/egc_pkg.sv
hw/rtl/egc_cpa_div.sv
hw/rtl/encounter_geometry_classifier.sv
verif/tb.sv
